@@ hw/rtl/srmq_pkg.sv @@
// Shared types and constants for the segmented ring mark queue.
// No dependencies; imported by srmq_ram, srmq_ctrl and the top level.
`default_nettype none

package srmq_pkg;

  localparam int REF_W  = 48;
  localparam int HELD_W = 8;

  localparam int SEGMENT_SLOTS_DEFAULT = 16;
  localparam int RING_SEGMENTS_DEFAULT = 8;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_DROP = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // index width for n entries, at least one bit
  function automatic int idx_width(input int n);
    idx_width = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/segmented_ring_mark_queue.sv @@
// Top level of the segmented ring mark queue: controller plus slot store.
// Depends on srmq_pkg, srmq_ctrl and srmq_ram.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ----------------------------------
//  command   start & !busy        func, object_ref
//  result    done (one cycle)     status, entry, last, held
//
// Push, drop and the unused code do not raise busy: the result shows on the
// cycle after the transfer, so commands can follow back to back. A read
// holds busy while it streams the head segment, one slot per cycle,
// limited by the single read port of the slot store.
// Reset (rst, synchronous) empties the queue at once; no clearing pass is
// run, since slot contents are qualified by the head/tail/fill registers.
// The receiver cannot stall; each result is valid for exactly one cycle.
`default_nettype none

module segmented_ring_mark_queue #(
  parameter int SEGMENT_SLOTS = srmq_pkg::SEGMENT_SLOTS_DEFAULT,
  parameter int RING_SEGMENTS = srmq_pkg::RING_SEGMENTS_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire  [1:0]                   func,
  input  wire  [srmq_pkg::REF_W-1:0]   object_ref,
  output logic                         done,
  output logic                         status,
  output logic [srmq_pkg::REF_W-1:0]   entry,
  output logic                         last,
  output logic [srmq_pkg::HELD_W-1:0]  held
);
  import srmq_pkg::*;

  localparam int DEPTH  = SEGMENT_SLOTS * RING_SEGMENTS;
  localparam int ADDR_W = idx_width(DEPTH);

  // slot store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [REF_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REF_W-1:0]  ram_rdata;

  // pointer registers, decode and the read sequencer
  srmq_ctrl #(
    .SEGMENT_SLOTS (SEGMENT_SLOTS),
    .RING_SEGMENTS (RING_SEGMENTS),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .object_ref (object_ref),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .entry      (entry),
    .last       (last),
    .held       (held),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // slot store, segment-major: address = segment * SEGMENT_SLOTS + slot
  srmq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/srmq_ram.sv @@
// Slot store: single write port, single read port, registered read data.
// Depends on srmq_pkg for the reference width.
`default_nettype none

module srmq_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [ADDR_W-1:0]           waddr,
  input  wire  [srmq_pkg::REF_W-1:0]  wdata,
  input  wire                         re,
  input  wire  [ADDR_W-1:0]           raddr,
  output logic [srmq_pkg::REF_W-1:0]  rdata
);
  import srmq_pkg::*;

  logic [REF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/srmq_ctrl.sv @@
// Queue controller: head/tail/fill/count registers, command decode and
// the segment read sequencer. Depends on srmq_pkg; drives srmq_ram.
`default_nettype none

module srmq_ctrl #(
  parameter int SEGMENT_SLOTS = srmq_pkg::SEGMENT_SLOTS_DEFAULT,
  parameter int RING_SEGMENTS = srmq_pkg::RING_SEGMENTS_DEFAULT,
  parameter int ADDR_W        = 7
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [1:0]                   func,
  input  wire  [srmq_pkg::REF_W-1:0]   object_ref,
  output logic                         busy,
  output logic                         done,
  output logic                         status,
  output logic [srmq_pkg::REF_W-1:0]   entry,
  output logic                         last,
  output logic [srmq_pkg::HELD_W-1:0]  held,
  output logic                         ram_we,
  output logic [ADDR_W-1:0]            ram_waddr,
  output logic [srmq_pkg::REF_W-1:0]   ram_wdata,
  output logic                         ram_re,
  output logic [ADDR_W-1:0]            ram_raddr,
  input  wire  [srmq_pkg::REF_W-1:0]   ram_rdata
);
  import srmq_pkg::*;

  localparam int SEG_W  = idx_width(RING_SEGMENTS);
  localparam int SLOT_W = idx_width(SEGMENT_SLOTS);
  localparam int FILL_W = $clog2(SEGMENT_SLOTS + 1);

  localparam logic [SEG_W-1:0]  LAST_SEG  = SEG_W'(RING_SEGMENTS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SEGMENT_SLOTS - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SEGMENT_SLOTS);
  localparam logic [HELD_W-1:0] SEG_HELD  = HELD_W'(SEGMENT_SLOTS);

  function automatic logic [ADDR_W-1:0] seg_base(input logic [SEG_W-1:0] s);
    seg_base = ADDR_W'(s) * ADDR_W'(SEGMENT_SLOTS);
  endfunction

  state_t              state, state_next;
  logic [SEG_W-1:0]    head, head_next;
  logic [SEG_W-1:0]    tail, tail_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [HELD_W-1:0]   total_held, total_held_next;
  logic [SLOT_W-1:0]   slot_idx, slot_idx_next;
  logic                res_valid, res_valid_next;
  status_t             res_status, res_status_next;

  logic                accept;
  logic [SEG_W-1:0]    head_adv, tail_adv;
  logic                keep;

  assign accept   = start && !busy;
  assign head_adv = (head == LAST_SEG) ? '0 : head + SEG_W'(1);
  assign tail_adv = (tail == LAST_SEG) ? '0 : tail + SEG_W'(1);

  // every slot of a non-tail head segment was filled; the tail only up to fill
  assign keep = (head != tail) || (FILL_W'(slot_idx) < fill);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_READ) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (slot_idx == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = 1'b0;
    done   = res_valid;
    status = res_status;
    entry  = '0;
    last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_READ: begin
        busy   = 1'b1;
        done   = 1'b1;
        status = STATUS_DONE;
        entry  = keep ? ram_rdata : '0;
        last   = (slot_idx == LAST_SLOT);
      end
      default: busy = 1'b0;
    endcase
  end

  assign held      = total_held;
  assign ram_wdata = object_ref;

  // datapath and memory control
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    total_held_next = total_held;
    slot_idx_next   = slot_idx;
    res_valid_next  = 1'b0;
    res_status_next = STATUS_DONE;
    ram_we          = 1'b0;
    ram_waddr       = seg_base(tail) + ADDR_W'(SLOT_W'(fill));
    ram_re          = 1'b0;
    ram_raddr       = seg_base(head);

    if (accept) begin
      unique case (func)
        FUNC_PUSH: begin
          res_valid_next = 1'b1;
          if (fill >= FULL_FILL) begin
            if (tail_adv == head) begin
              res_status_next = STATUS_FULL;
            end else begin
              tail_next       = tail_adv;
              fill_next       = FILL_W'(1);
              total_held_next = total_held + HELD_W'(1);
              ram_we          = 1'b1;
              ram_waddr       = seg_base(tail_adv);
            end
          end else begin
            fill_next       = fill + FILL_W'(1);
            total_held_next = total_held + HELD_W'(1);
            ram_we          = 1'b1;
          end
        end
        FUNC_READ: begin
          ram_re        = 1'b1;
          ram_raddr     = seg_base(head);
          slot_idx_next = '0;
        end
        FUNC_DROP: begin
          res_valid_next = 1'b1;
          if (head != tail) begin
            head_next       = head_adv;
            total_held_next = total_held - SEG_HELD;
          end else begin
            fill_next       = '0;
            total_held_next = '0;
          end
        end
        default: begin
          res_valid_next = 1'b1;
        end
      endcase
    end else if (state == ST_READ && slot_idx != LAST_SLOT) begin
      // prefetch the following slot while this one is on the outputs
      ram_re        = 1'b1;
      ram_raddr     = seg_base(head) + ADDR_W'(slot_idx) + ADDR_W'(1);
      slot_idx_next = slot_idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      total_held <= '0;
      slot_idx   <= '0;
      res_valid  <= 1'b0;
      res_status <= STATUS_DONE;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      fill       <= fill_next;
      total_held <= total_held_next;
      slot_idx   <= slot_idx_next;
      res_valid  <= res_valid_next;
      res_status <= res_status_next;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for segmented_ring_mark_queue: directed and random command traffic
// checked against an in-bench prediction of the ring. Depends on srmq_pkg.
`timescale 1ns / 1ps

module tb;
  import srmq_pkg::*;

  localparam int SLOTS      = SEGMENT_SLOTS_DEFAULT;
  localparam int SEGS       = RING_SEGMENTS_DEFAULT;
  localparam int STALL_MAX  = 500;  // cycles with no transfer and no result
  localparam int DRAIN_WAIT = 40;   // settle time after the last result

  typedef struct packed {
    status_t            status;
    logic [REF_W-1:0]   entry;
    logic               last;
    logic [HELD_W-1:0]  held;
  } mark_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         func = FUNC_PUSH;
  logic [REF_W-1:0]   object_ref = '0;
  logic               busy;
  logic               done;
  logic               status;
  logic [REF_W-1:0]   entry;
  logic               last;
  logic [HELD_W-1:0]  held;

  // predicted ring contents and pointers
  logic [REF_W-1:0]   ring_slots [SLOTS*SEGS];
  int unsigned        head_seg;
  int unsigned        tail_seg;
  int unsigned        fill_pos;
  int unsigned        held_refs;

  mark_result_t       pending_results [$];

  int                 error_count = 0;
  int                 cmds_sent = 0;
  int                 results_seen = 0;
  int                 refused_pushes = 0;
  int                 reads_sent = 0;
  int                 idle_pct = 7;
  int                 stall_cycles = 0;

  segmented_ring_mark_queue dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .object_ref (object_ref),
    .done       (done),
    .status     (status),
    .entry      (entry),
    .last       (last),
    .held       (held)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void wipe_segment(input int unsigned seg);
    for (int j = 0; j < SLOTS; j++) ring_slots[seg*SLOTS + j] = '0;
  endfunction

  // Apply one accepted command to the predicted ring and queue up the
  // results it must produce.
  function automatic void predict_mark_queue(input func_t f, input logic [REF_W-1:0] r);
    mark_result_t res;
    int unsigned  next_seg;
    res.status = STATUS_DONE;
    res.entry  = '0;
    res.last   = 1'b1;
    case (f)
      FUNC_PUSH: begin
        if (fill_pos >= SLOTS) begin
          next_seg = (tail_seg + 1) % SEGS;
          if (next_seg == head_seg) begin
            // ring full: refused, nothing changes
            res.status = STATUS_FULL;
            refused_pushes++;
          end else begin
            tail_seg = next_seg;
            fill_pos = 0;
            wipe_segment(tail_seg);
          end
        end
        if (res.status == STATUS_DONE) begin
          ring_slots[tail_seg*SLOTS + fill_pos] = r;
          fill_pos++;
          held_refs++;
        end
        res.held = HELD_W'(held_refs);
        pending_results.push_back(res);
      end
      FUNC_READ: begin
        // whole head segment, unfilled slots read as zero
        res.held = HELD_W'(held_refs);
        for (int j = 0; j < SLOTS; j++) begin
          res.entry = ring_slots[head_seg*SLOTS + j];
          res.last  = (j == SLOTS - 1);
          pending_results.push_back(res);
        end
      end
      FUNC_DROP: begin
        wipe_segment(head_seg);
        if (head_seg != tail_seg) begin
          head_seg  = (head_seg + 1) % SEGS;
          held_refs = held_refs - SLOTS;
        end else begin
          // only segment: cleared in place
          fill_pos  = 0;
          held_refs = 0;
        end
        res.held = HELD_W'(held_refs);
        pending_results.push_back(res);
      end
      default: begin
        res.held = HELD_W'(held_refs);
        pending_results.push_back(res);
      end
    endcase
  endfunction

  function automatic logic [REF_W-1:0] random_ref();
    logic [REF_W-1:0] v;
    v = REF_W'({$urandom, $urandom});
    if ($urandom_range(0, 15) == 0) v = '0;
    return v;
  endfunction

  // One command transfer. start is left high on return so back-to-back
  // commands never lower and raise it in the same step.
  task automatic send_cmd(input func_t f, input logic [REF_W-1:0] r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    func       <= f;
    object_ref <= r;
    do @(posedge clk); while (busy !== 1'b0);
    predict_mark_queue(f, r);
    cmds_sent++;
    if (f == FUNC_READ) reads_sent++;
  endtask

  // Hold off until every expected result is back.
  task automatic wait_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_cmd(FUNC_READ, random_ref());
    send_cmd(FUNC_DROP, {REF_W{1'b1}});
    send_cmd(FUNC_NOP, {REF_W{1'b1}});
    send_cmd(FUNC_NOP, '0);
    send_cmd(FUNC_READ, '0);
  endtask

  task automatic test_reference_values();
    send_cmd(FUNC_PUSH, '0);
    send_cmd(FUNC_PUSH, {REF_W{1'b1}});
    send_cmd(FUNC_PUSH, REF_W'(1));
    send_cmd(FUNC_PUSH, {(REF_W/2){2'b10}});
    send_cmd(FUNC_PUSH, {(REF_W/2){2'b01}});
    send_cmd(FUNC_NOP, random_ref());
    send_cmd(FUNC_READ, random_ref());
    send_cmd(FUNC_DROP, random_ref());
    send_cmd(FUNC_READ, '0);
    send_cmd(FUNC_PUSH, random_ref());
    send_cmd(FUNC_DROP, '0);
  endtask

  // Fill every segment, push past full, then drain to empty and beyond.
  task automatic test_full_ring();
    int refused_at_entry;
    refused_at_entry = refused_pushes;
    idle_pct = 0;
    while (refused_pushes == refused_at_entry) begin
      if ($urandom_range(0, 19) == 0) send_cmd(FUNC_READ, random_ref());
      else send_cmd(FUNC_PUSH, random_ref());
    end
    send_cmd(FUNC_PUSH, random_ref());
    send_cmd(FUNC_READ, random_ref());
    send_cmd(FUNC_PUSH, random_ref());
    for (int k = 0; k < SEGS + 1; k++) begin
      send_cmd(FUNC_DROP, random_ref());
      if (k % 3 == 0) send_cmd(FUNC_READ, random_ref());
    end
    idle_pct = 7;
  endtask

  // Random mix in the given percentages: a push-heavy batch builds the queue
  // back up, then a batch with a larger share of drops follows.
  task automatic test_random_traffic(input int n_items, input int push_pct,
                                     input int read_pct, input int drop_pct);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) send_cmd(FUNC_PUSH, random_ref());
      else if (pick < push_pct + read_pct) send_cmd(FUNC_READ, random_ref());
      else if (pick < push_pct + read_pct + drop_pct) send_cmd(FUNC_DROP, random_ref());
      else send_cmd(FUNC_NOP, random_ref());
    end
  endtask

  // result checker: every strobe is matched with the oldest expectation
  always @(posedge clk) begin : result_check
    mark_result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_error("result strobe with nothing expected");
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (done !== 1'b1)
          flag_error("done strobe is unknown");
        if (status !== want.status)
          flag_error($sformatf("status %b, expected %b", status, want.status));
        if (entry !== want.entry)
          flag_error($sformatf("entry %h, expected %h", entry, want.entry));
        if (last !== want.last)
          flag_error($sformatf("last %b, expected %b", last, want.last));
        if (held !== want.held)
          flag_error($sformatf("held %0d, expected %0d", held, want.held));
      end
    end
  end

  // watchdog: no command transfer and no result for too long ends the run
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("timeout: no transfer for %0d cycles", STALL_MAX);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS*SEGS; i++) ring_slots[i] = '0;
    head_seg  = 0;
    tail_seg  = 0;
    fill_pos  = 0;
    held_refs = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_reference_values();
    wait_drain();
    test_full_ring();
    test_random_traffic(16, 80, 8, 7);
    wait_drain();
    test_random_traffic(12, 50, 15, 25);

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d commands (%0d segment reads, %0d refused pushes)",
             cmds_sent, reads_sent, refused_pushes);
    $display("checked %0d results, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
